/* design/chm_pkg.sv */
`default_nettype none
package chm_pkg;

    localparam int NUM_BUCKETS_DEF  = 64;
    localparam int POOL_ENTRIES_DEF = 256;

    localparam int KIND_W   = 2;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

    // address width of a store of the given depth, at least one bit
    function automatic int addr_w(input int depth);
        int w;
        begin
            w = $clog2(depth);
            return (w < 1) ? 1 : w;
        end
    endfunction

endpackage
`default_nettype wire

/* design/chm_ram.sv */
`default_nettype none
module chm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                              aclk,
    input  wire logic                              we,
    input  wire logic [chm_pkg::addr_w(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                  wdata,
    input  wire logic [chm_pkg::addr_w(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]                  rdata
);
    import chm_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* design/chm_mod.sv */
`default_nettype none
module chm_mod #(
    parameter int NUM_BUCKETS = chm_pkg::NUM_BUCKETS_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    start,
    input  wire logic [chm_pkg::KEY_W-1:0]               key_in,
    output logic                                         done,
    output logic [chm_pkg::addr_w(NUM_BUCKETS)-1:0]      bucket
);
    import chm_pkg::*;

    localparam int BW    = addr_w(NUM_BUCKETS);
    localparam int PW    = 2 * KEY_W;
    localparam int SHIFT = KEY_W - 1 + $clog2(NUM_BUCKETS);
    localparam logic [PW-1:0]    RECIP_WIDE = (PW'(1) << SHIFT) / PW'(NUM_BUCKETS);
    localparam logic [KEY_W-1:0] RECIP      = RECIP_WIDE[KEY_W-1:0];
    localparam logic [KEY_W-1:0] DIVISOR    = KEY_W'(NUM_BUCKETS);
    // four register stages behind the key register
    localparam logic [1:0]       LAST_STEP  = 2'd3;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [PW-1:0]    prod_reg, prod_next;
    logic [KEY_W-1:0] quot;
    logic [KEY_W-1:0] qn_reg, qn_next;
    logic [KEY_W-1:0] diff_reg, diff_next;
    logic [BW-1:0]    rem_reg, rem_next;

    // reciprocal estimate of the quotient is at most one low,
    // so a single compare and subtract finishes the remainder
    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        key_next  = key_reg;
        quot      = KEY_W'(prod_reg >> SHIFT);
        prod_next = PW'(key_reg) * PW'(RECIP);
        qn_next   = quot * DIVISOR;
        diff_next = key_reg - qn_reg;
        if (diff_reg >= DIVISOR) begin
            rem_next = BW'(diff_reg - DIVISOR);
        end else begin
            rem_next = BW'(diff_reg);
        end
        if (start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            key_next  = key_in;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        key_reg  <= key_next;
        prod_reg <= prod_next;
        qn_reg   <= qn_next;
        diff_reg <= diff_next;
        rem_reg  <= rem_next;
    end

    assign done   = done_reg;
    assign bucket = rem_reg;

endmodule
`default_nettype wire

/* design/chained_hash_map_engine.sv */
`default_nettype none
// timing: for a lookup, an overwrite or a miss m_valid follows the head read and the walk
//   over the chain entries visited; a new insert adds ST_ALLOC, a hit remove adds ST_REM2,
//   an unused kind goes straight to ST_ACT; a bucket count not a power of two adds ST_MOD
// requests: one at a time; s_ready rises in the same cycle as m_valid
// reset: a clearing pass over max(NUM_BUCKETS, POOL_ENTRIES) addresses empties the bucket heads
//   and links the free chain; no request is taken until it ends
module chained_hash_map_engine #(
    parameter int NUM_BUCKETS  = chm_pkg::NUM_BUCKETS_DEF,
    parameter int POOL_ENTRIES = chm_pkg::POOL_ENTRIES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [chm_pkg::KIND_W-1:0]    s_kind,
    input  wire logic [chm_pkg::KEY_W-1:0]     s_key,
    input  wire logic [chm_pkg::VAL_W-1:0]     s_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [chm_pkg::STATUS_W-1:0]  m_status,
    output logic                               m_key_was_present,
    output logic      [chm_pkg::VAL_W-1:0]     m_value_out
);
    import chm_pkg::*;

    localparam int BW = addr_w(NUM_BUCKETS);
    localparam int AW = addr_w(POOL_ENTRIES);
    localparam int IW = $clog2(POOL_ENTRIES + 1);
    localparam int SWEEP = (NUM_BUCKETS > POOL_ENTRIES) ? NUM_BUCKETS : POOL_ENTRIES;
    localparam int CW = addr_w(SWEEP);
    localparam bit IS_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
    localparam logic [IW-1:0] EMPTY = IW'(POOL_ENTRIES);

    localparam logic [3:0] ST_INIT      = 4'd0;
    localparam logic [3:0] ST_IDLE      = 4'd1;
    localparam logic [3:0] ST_MOD       = 4'd2;
    localparam logic [3:0] ST_HEAD_RD   = 4'd3;
    localparam logic [3:0] ST_HEAD_WAIT = 4'd4;
    localparam logic [3:0] ST_WALK      = 4'd5;
    localparam logic [3:0] ST_ACT       = 4'd6;
    localparam logic [3:0] ST_ALLOC     = 4'd7;
    localparam logic [3:0] ST_REM2      = 4'd8;
    localparam logic [3:0] ST_FINISH    = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [IW-1:0]       free_reg, free_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic [IW-1:0]       head_reg, head_next;
    logic [IW-1:0]       cur_reg, cur_next;
    logic [IW-1:0]       prev_reg, prev_next;
    logic                hit_reg, hit_next;
    logic [IW-1:0]       hlink_reg, hlink_next;
    logic [VAL_W-1:0]    hval_reg, hval_next;
    logic [STATUS_W-1:0] rstat_reg, rstat_next;
    logic                rpres_reg, rpres_next;
    logic [VAL_W-1:0]    rval_reg, rval_next;
    logic                mv_reg, mv_next;
    logic [STATUS_W-1:0] mstat_reg, mstat_next;
    logic                mpres_reg, mpres_next;
    logic [VAL_W-1:0]    mval_reg, mval_next;

    logic                accept;
    logic                mod_done;
    logic [BW-1:0]       mod_bucket;
    logic [BW-1:0]       bkt;
    logic [KEY_W-1:0]    masked_key;

    logic                bh_we;
    logic [BW-1:0]       bh_waddr, bh_raddr;
    logic [IW-1:0]       bh_wdata, bh_rdata;
    logic                ek_we;
    logic [AW-1:0]       ek_waddr;
    logic [KEY_W-1:0]    ek_wdata, ek_rdata;
    logic                ev_we;
    logic [AW-1:0]       ev_waddr;
    logic [VAL_W-1:0]    ev_wdata, ev_rdata;
    logic                el_we;
    logic [AW-1:0]       el_waddr, el_raddr;
    logic [IW-1:0]       el_wdata, el_rdata;
    logic [AW-1:0]       ent_raddr;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign masked_key = key_reg & KEY_W'(NUM_BUCKETS - 1);
    assign bkt = IS_POW2 ? masked_key[BW-1:0] : mod_bucket;

    chm_mod #(
        .NUM_BUCKETS(NUM_BUCKETS)
    ) u_mod (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (accept),
        .key_in (s_key),
        .done   (mod_done),
        .bucket (mod_bucket)
    );

    chm_ram #(.WIDTH(IW), .DEPTH(NUM_BUCKETS)) u_bucket_head (
        .aclk(aclk), .we(bh_we), .waddr(bh_waddr), .wdata(bh_wdata),
        .raddr(bh_raddr), .rdata(bh_rdata)
    );

    chm_ram #(.WIDTH(KEY_W), .DEPTH(POOL_ENTRIES)) u_entry_key (
        .aclk(aclk), .we(ek_we), .waddr(ek_waddr), .wdata(ek_wdata),
        .raddr(ent_raddr), .rdata(ek_rdata)
    );

    chm_ram #(.WIDTH(VAL_W), .DEPTH(POOL_ENTRIES)) u_entry_value (
        .aclk(aclk), .we(ev_we), .waddr(ev_waddr), .wdata(ev_wdata),
        .raddr(ent_raddr), .rdata(ev_rdata)
    );

    chm_ram #(.WIDTH(IW), .DEPTH(POOL_ENTRIES)) u_entry_link (
        .aclk(aclk), .we(el_we), .waddr(el_waddr), .wdata(el_wdata),
        .raddr(el_raddr), .rdata(el_rdata)
    );

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        free_next  = free_reg;
        kind_next  = kind_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        head_next  = head_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        hit_next   = hit_reg;
        hlink_next = hlink_reg;
        hval_next  = hval_reg;
        rstat_next = rstat_reg;
        rpres_next = rpres_reg;
        rval_next  = rval_reg;
        mv_next    = mv_reg;
        mstat_next = mstat_reg;
        mpres_next = mpres_reg;
        mval_next  = mval_reg;

        bh_we     = 1'b0;
        bh_waddr  = bkt;
        bh_wdata  = free_reg;
        bh_raddr  = bkt;
        ek_we     = 1'b0;
        ek_waddr  = free_reg[AW-1:0];
        ek_wdata  = key_reg;
        ev_we     = 1'b0;
        ev_waddr  = free_reg[AW-1:0];
        ev_wdata  = val_reg;
        el_we     = 1'b0;
        el_waddr  = free_reg[AW-1:0];
        el_wdata  = head_reg;
        ent_raddr = cur_reg[AW-1:0];
        el_raddr  = cur_reg[AW-1:0];

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            ST_INIT: begin
                if ({1'b0, cnt_reg} < (CW+1)'(NUM_BUCKETS)) begin
                    bh_we    = 1'b1;
                    bh_waddr = cnt_reg[BW-1:0];
                    bh_wdata = EMPTY;
                end
                if ({1'b0, cnt_reg} < (CW+1)'(POOL_ENTRIES)) begin
                    el_we    = 1'b1;
                    el_waddr = cnt_reg[AW-1:0];
                    el_wdata = IW'(IW'(cnt_reg) + IW'(1));
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(SWEEP - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    kind_next = s_kind;
                    key_next  = s_key;
                    val_next  = s_value;
                    hit_next  = 1'b0;
                    if (s_kind != KIND_INSERT && s_kind != KIND_LOOKUP &&
                        s_kind != KIND_REMOVE) begin
                        state_next = ST_ACT;
                    end else if (IS_POW2) begin
                        state_next = ST_HEAD_RD;
                    end else begin
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    state_next = ST_HEAD_RD;
                end
            end
            ST_HEAD_RD: begin
                state_next = ST_HEAD_WAIT;
            end
            ST_HEAD_WAIT: begin
                head_next = bh_rdata;
                prev_next = EMPTY;
                cur_next  = bh_rdata;
                ent_raddr = bh_rdata[AW-1:0];
                el_raddr  = bh_rdata[AW-1:0];
                if (bh_rdata >= EMPTY) begin
                    state_next = ST_ACT;
                end else begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                // entry data for cur_reg arrives this cycle
                if (ek_rdata == key_reg) begin
                    hit_next   = 1'b1;
                    hlink_next = el_rdata;
                    hval_next  = ev_rdata;
                    state_next = ST_ACT;
                end else begin
                    prev_next = cur_reg;
                    cur_next  = el_rdata;
                    ent_raddr = el_rdata[AW-1:0];
                    el_raddr  = el_rdata[AW-1:0];
                    if (el_rdata >= EMPTY) begin
                        state_next = ST_ACT;
                    end
                end
            end
            ST_ACT: begin
                rstat_next = STATUS_ABSENT;
                rpres_next = 1'b0;
                rval_next  = '0;
                state_next = ST_FINISH;
                case (kind_reg)
                    KIND_INSERT: begin
                        if (hit_reg) begin
                            ev_we      = 1'b1;
                            ev_waddr   = cur_reg[AW-1:0];
                            rstat_next = STATUS_OK;
                            rpres_next = 1'b1;
                        end else if (free_reg >= EMPTY) begin
                            rstat_next = STATUS_FULL;
                        end else begin
                            el_raddr   = free_reg[AW-1:0];
                            state_next = ST_ALLOC;
                        end
                    end
                    KIND_LOOKUP: begin
                        if (hit_reg) begin
                            rstat_next = STATUS_OK;
                            rpres_next = 1'b1;
                            rval_next  = hval_reg;
                        end
                    end
                    KIND_REMOVE: begin
                        if (hit_reg) begin
                            if (prev_reg < EMPTY) begin
                                el_we    = 1'b1;
                                el_waddr = prev_reg[AW-1:0];
                                el_wdata = hlink_reg;
                            end else begin
                                bh_we    = 1'b1;
                                bh_wdata = hlink_reg;
                            end
                            rstat_next = STATUS_OK;
                            rpres_next = 1'b1;
                            state_next = ST_REM2;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_ALLOC: begin
                // push the free head entry onto the bucket chain
                free_next  = el_rdata;
                ek_we      = 1'b1;
                ev_we      = 1'b1;
                el_we      = 1'b1;
                bh_we      = 1'b1;
                rstat_next = STATUS_OK;
                state_next = ST_FINISH;
            end
            ST_REM2: begin
                el_we      = 1'b1;
                el_waddr   = cur_reg[AW-1:0];
                el_wdata   = free_reg;
                free_next  = cur_reg;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    mstat_next = rstat_reg;
                    mpres_next = rpres_reg;
                    mval_next  = rval_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
            free_reg  <= '0;
            hit_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            free_reg  <= free_next;
            hit_reg   <= hit_next;
            mv_reg    <= mv_next;
        end
        kind_reg  <= kind_next;
        key_reg   <= key_next;
        val_reg   <= val_next;
        head_reg  <= head_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        hlink_reg <= hlink_next;
        hval_reg  <= hval_next;
        rstat_reg <= rstat_next;
        rpres_reg <= rpres_next;
        rval_reg  <= rval_next;
        mstat_reg <= mstat_next;
        mpres_reg <= mpres_next;
        mval_reg  <= mval_next;
    end

    assign m_valid           = mv_reg;
    assign m_status          = mstat_reg;
    assign m_key_was_present = mpres_reg;
    assign m_value_out       = mval_reg;

endmodule
`default_nettype wire

/* test/chained_hash_map_engine_tb.sv */
module chained_hash_map_engine_tb;
    import chm_pkg::*;

    localparam int NUM_BUCKETS     = NUM_BUCKETS_DEF;
    localparam int POOL_ENTRIES    = POOL_ENTRIES_DEF;
    localparam int SLOT_W          = addr_w(POOL_ENTRIES);
    localparam int LINK_W          = SLOT_W + 1;
    localparam int BUCKET_W        = addr_w(NUM_BUCKETS);
    localparam int KEY_POOL_SIZE   = 32;
    localparam int POOL_IDX_W      = addr_w(KEY_POOL_SIZE);
    localparam int CROWDED_BUCKET  = 5;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = POOL_ENTRIES + 64;

    localparam logic [LINK_W-1:0] NO_SLOT     = LINK_W'(POOL_ENTRIES);
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                was_present;
        logic [VAL_W-1:0]    value_out;
    } map_reply_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [KIND_W-1:0]   s_kind = '0;
    logic [KEY_W-1:0]    s_key = '0;
    logic [VAL_W-1:0]    s_value = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic                m_key_was_present;
    logic [VAL_W-1:0]    m_value_out;

    // shadow copy of the map
    logic [LINK_W-1:0] chain_head [NUM_BUCKETS];
    logic [KEY_W-1:0]  slot_key   [POOL_ENTRIES];
    logic [VAL_W-1:0]  slot_value [POOL_ENTRIES];
    logic [LINK_W-1:0] slot_next  [POOL_ENTRIES];
    logic [LINK_W-1:0] free_slot;

    map_reply_t       expected_replies [$];
    logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

    int fail_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    bit hold_off_req   = 1'b0;

    chained_hash_map_engine dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_key             (s_key),
        .s_value           (s_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_key_was_present (m_key_was_present),
        .m_value_out       (m_value_out)
    );

    always #5 aclk = ~aclk;

    function automatic void clear_map();
        for (int i = 0; i < NUM_BUCKETS; i++) chain_head[i] = NO_SLOT;
        for (int i = 0; i < POOL_ENTRIES; i++) begin
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_next[i]  = LINK_W'(i + 1);
        end
        free_slot = '0;
    endfunction

    function automatic logic [KEY_W-1:0] pick_pool_key();
        return key_pool[POOL_IDX_W'($urandom_range(KEY_POOL_SIZE-1))];
    endfunction

    function automatic logic [KEY_W-1:0] pick_live_key();
        return slot_key[SLOT_W'($urandom_range(POOL_ENTRIES-1))];
    endfunction

    // walk the key's chain; pred gets the entry ahead of the hit
    function automatic logic [LINK_W-1:0] locate_key(input logic [KEY_W-1:0] key,
                                                     output logic [LINK_W-1:0] pred);
        logic [LINK_W-1:0] cur;
        logic [LINK_W-1:0] trail;
        cur   = chain_head[BUCKET_W'(key % NUM_BUCKETS)];
        trail = NO_SLOT;
        pred  = NO_SLOT;
        for (int n = 0; n < POOL_ENTRIES; n++) begin
            if (cur >= POOL_ENTRIES) break;
            if (slot_key[cur[SLOT_W-1:0]] == key) begin
                pred = trail;
                return cur;
            end
            trail = cur;
            cur   = slot_next[cur[SLOT_W-1:0]];
        end
        return NO_SLOT;
    endfunction

    function automatic map_reply_t apply_request(input logic [KIND_W-1:0] kind,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [VAL_W-1:0] value);
        map_reply_t          r;
        logic [LINK_W-1:0]   hit;
        logic [LINK_W-1:0]   pred;
        logic [LINK_W-1:0]   slot;
        logic [BUCKET_W-1:0] b;
        r.status      = STATUS_ABSENT;
        r.was_present = 1'b0;
        r.value_out   = '0;
        b = BUCKET_W'(key % NUM_BUCKETS);
        if (kind == KIND_UNUSED) return r;
        hit = locate_key(key, pred);
        case (kind)
            KIND_INSERT: begin
                if (hit != NO_SLOT) begin
                    slot_value[hit[SLOT_W-1:0]] = value;
                    r.status                    = STATUS_OK;
                    r.was_present               = 1'b1;
                end else if (free_slot >= POOL_ENTRIES) begin
                    r.status = STATUS_FULL;
                end else begin
                    slot                         = free_slot;
                    free_slot                    = slot_next[slot[SLOT_W-1:0]];
                    slot_key[slot[SLOT_W-1:0]]   = key;
                    slot_value[slot[SLOT_W-1:0]] = value;
                    slot_next[slot[SLOT_W-1:0]]  = chain_head[b];
                    chain_head[b]                = slot;
                    r.status                     = STATUS_OK;
                end
            end
            KIND_LOOKUP: begin
                if (hit != NO_SLOT) begin
                    r.status      = STATUS_OK;
                    r.was_present = 1'b1;
                    r.value_out   = slot_value[hit[SLOT_W-1:0]];
                end
            end
            KIND_REMOVE: begin
                if (hit != NO_SLOT) begin
                    if (pred != NO_SLOT) begin
                        slot_next[pred[SLOT_W-1:0]] = slot_next[hit[SLOT_W-1:0]];
                    end else begin
                        chain_head[b] = slot_next[hit[SLOT_W-1:0]];
                    end
                    slot_next[hit[SLOT_W-1:0]] = free_slot;
                    free_slot                  = hit;
                    r.status                   = STATUS_OK;
                    r.was_present              = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // drives one request beat, waits for it to be taken, then predicts its reply
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            s_kind  <= KIND_W'($urandom);
            s_key   <= $urandom;
            s_value <= $urandom;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_key   <= key;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        expected_replies.push_back(apply_request(kind, key, value));
    endtask

    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(KIND_LOOKUP, 32'h0000_0000, 32'h0);
        send_request(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_request(KIND_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(KIND_LOOKUP, 32'h0000_0000, 32'h0);
        send_request(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // three keys sharing bucket zero
        send_request(KIND_INSERT, 32'h0000_0040, 32'hA5A5_5A5A);
        send_request(KIND_INSERT, 32'h0000_0080, 32'h5A5A_A5A5);
        send_request(KIND_LOOKUP, 32'h0000_0000, 32'h0);
        send_request(KIND_INSERT, 32'h0000_0040, 32'h1234_5678);
        send_request(KIND_LOOKUP, 32'h0000_0040, 32'h0);
        send_request(KIND_REMOVE, 32'h0000_0040, 32'h0);
        send_request(KIND_LOOKUP, 32'h0000_0040, 32'h0);
        send_request(KIND_REMOVE, 32'h0000_0080, 32'h0);
        send_request(KIND_REMOVE, 32'h0000_0000, 32'h0);
        send_request(KIND_REMOVE, 32'h0000_0000, 32'h0);
        send_request(KIND_UNUSED, 32'hFFFF_FFFF, 32'h0);
        send_request(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_request(KIND_INSERT, 32'h8000_0000, 32'h8765_4321);
        send_request(KIND_LOOKUP, 32'h8000_0040, 32'h0);
        send_request(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_request(KIND_REMOVE, 32'h8000_0000, 32'h0);
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        int               roll;
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 40) kind = KIND_INSERT;
            else if (roll < 70) kind = KIND_LOOKUP;
            else if (roll < 95) kind = KIND_REMOVE;
            else kind = KIND_UNUSED;
            // mostly recurring keys so that lookups and removes hit
            if ($urandom_range(99) < 75) key = pick_pool_key();
            else key = $urandom;
            send_request(kind, key, $urandom);
        end
    endtask

    task automatic test_pool_exhaustion();
        logic [KEY_W-1:0]  key;
        logic [LINK_W-1:0] pred;
        send_idle_pct  = 26;
        recv_stall_pct = 26;
        while (free_slot != NO_SLOT) begin
            do key = $urandom; while (locate_key(key, pred) != NO_SLOT);
            send_request(KIND_INSERT, key, $urandom);
        end
        // every slot is live now: fresh keys are refused, existing ones still update
        repeat (6) send_request(KIND_INSERT, $urandom, $urandom);
        repeat (6) send_request(KIND_INSERT, pick_live_key(), $urandom);
        repeat (4) send_request(KIND_LOOKUP, pick_live_key(), $urandom);
        repeat (16) send_request(KIND_REMOVE, pick_live_key(), $urandom);
        repeat (8) send_request(KIND_INSERT, $urandom, $urandom);
        repeat (8) send_request(KIND_LOOKUP, pick_live_key(), $urandom);
    endtask

    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 1'b1;
        repeat (16) begin
            if ($urandom_range(1)) send_request(KIND_LOOKUP, pick_pool_key(), $urandom);
            else send_request(KIND_INSERT, pick_pool_key(), $urandom);
        end
    endtask

    // result side: random stalls plus a long hold-off whenever hold_off_req is set
    always @(posedge aclk) begin
        if (hold_off_req) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : check_replies
        map_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected beat status %0d present %0d value %h", $time,
                         m_status, m_key_was_present, m_value_out);
                fail_count++;
            end else begin
                want = expected_replies.pop_front();
                if (m_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, m_status);
                    fail_count++;
                end
                if (m_key_was_present !== want.was_present) begin
                    $display("%0t: key_was_present expected %0d actual %0d", $time,
                             want.was_present, m_key_was_present);
                    fail_count++;
                end
                if (m_value_out !== want.value_out) begin
                    $display("%0t: value_out expected %h actual %h", $time, want.value_out,
                             m_value_out);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < KEY_POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
            // a third of the keys crowd into one bucket for long chains
            if (i < KEY_POOL_SIZE / 3) key_pool[i] = key_pool[i] * NUM_BUCKETS + CROWDED_BUCKET;
        end
        clear_map();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_random_traffic(30, 0, 0);
        test_random_traffic(30, 85, 0);
        test_random_traffic(30, 0, 85);
        test_random_traffic(30, 26, 26);
        test_pool_exhaustion();
        test_output_backpressure();
        s_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
